/* rtl/core/assert_macros.svh */
// Assertion macros shared by the allocator RTL.
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked assertion, disabled while reset is asserted.
`define ASSERT_CLK(label, prop, msg) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (prop)) \
    else $error(msg);

// Clocked assertion that also holds during reset.
`define ASSERT_ALWAYS(label, prop, msg) \
    label: assert property (@(posedge i_clk) (prop)) else $error(msg);

`endif

/* rtl/core/bfa_pkg.sv */
// Types and constants of the best-fit block allocator.
// No dependencies.
package bfa_pkg;

    localparam int unsigned AW        = 32;
    localparam int unsigned CFG_IDX_W = 2;

    localparam logic [AW-1:0] RESET_BASE = 32'h1234ABCD;
    localparam logic [AW-1:0] RESET_SIZE = 32'd409600;

    localparam logic [1:0] ACT_ALLOC = 2'd0;
    localparam logic [1:0] ACT_FREE  = 2'd1;
    localparam logic [1:0] ACT_INIT  = 2'd2;

    localparam logic [2:0] ST_OK      = 3'd0;
    localparam logic [2:0] ST_NOFIT   = 3'd1;
    localparam logic [2:0] ST_ZERO    = 3'd2;
    localparam logic [2:0] ST_BADFREE = 3'd3;
    localparam logic [2:0] ST_FULL    = 3'd4;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_BASE = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_HEAP_SIZE = 2'd1;

    typedef struct packed {
        logic          valid;
        logic          alloc;
        logic [AW-1:0] start;
        logic [AW-1:0] size;
    } t_entry;

endpackage

/* rtl/core/bfa_cell.sv */
// One table slot of the allocator ring; takes its neighbor's entry on shift.
// Depends on bfa_pkg.
module bfa_cell import bfa_pkg::*; #(
    parameter bit RST_VALID = 1'b0
) (
    input  logic   i_clk,
    input  logic   i_rst_n,
    input  logic   i_shift,
    input  t_entry i_entry,
    output t_entry o_entry
);

    t_entry r_entry;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_entry.valid <= RST_VALID;
            r_entry.alloc <= 1'b0;
            r_entry.start <= RST_VALID ? RESET_BASE : '0;
            r_entry.size  <= RST_VALID ? RESET_SIZE : '0;
        end else if (i_shift) begin
            r_entry <= i_entry;
        end
    end

    assign o_entry = r_entry;

endmodule

/* rtl/core/best_fit_block_allocator.sv */
// Best-fit block allocator: ring of table cells plus the scan sequencer.
// Depends on bfa_pkg, bfa_cell and assert_macros.svh.
//
//  channel   | dir | handshake            | payload
//  s_axis    | in  | tvalid/tready        | tuser action, tdata request/free address
//  m_axis    | out | tvalid/tready        | tuser status, tdata address/block size
//  cfg       | in  | i_cfg_valid/ready    | index, data
//
// The table rotates one slot a cycle through the head cell while a scan state is active; one pass visits every cell.
// Allocate: 2 passes with a decision state between; free: 3 passes with a decision state after each of the first two;
// init: 1 pass; zero size, free of zero and action 3 go straight to the done state.
// Reset restores one free block spanning the reset heap; no clearing pass.
// A result waiting at m_axis holds the sequencer in its done state until taken.
// Configuration writes are taken only while the sequencer is idle.
module best_fit_block_allocator import bfa_pkg::*; #(
    parameter int unsigned MAX_BLOCKS = 64
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_s_axis_tvalid,
    output logic                 o_s_axis_tready,
    input  logic [63:0]          i_s_axis_tdata,  // request_size[31:0], free_address[63:32]
    input  logic [1:0]           i_s_axis_tuser,  // action[1:0]
    output logic                 o_m_axis_tvalid,
    input  logic                 i_m_axis_tready,
    output logic [63:0]          o_m_axis_tdata,  // address[31:0], block_size[63:32]
    output logic [2:0]           o_m_axis_tuser,  // status[2:0]
    input  logic                 i_cfg_valid,
    output logic                 o_cfg_ready,
    input  logic [CFG_IDX_W-1:0] i_cfg_index,
    input  logic [AW-1:0]        i_cfg_data
);
    `include "assert_macros.svh"

    localparam int unsigned CW = (MAX_BLOCKS > 1) ? $clog2(MAX_BLOCKS) : 1;
    localparam logic [CW-1:0] LAST = CW'(MAX_BLOCKS - 1);

    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_SCAN1 = 3'd1;
    localparam logic [2:0] S_DEC1  = 3'd2;
    localparam logic [2:0] S_SCAN2 = 3'd3;
    localparam logic [2:0] S_DEC2  = 3'd4;
    localparam logic [2:0] S_SCAN3 = 3'd5;
    localparam logic [2:0] S_DONE  = 3'd6;

    t_entry q [MAX_BLOCKS];
    t_entry head, wb;
    logic   shift;

    genvar g;
    generate
        for (g = 0; g < MAX_BLOCKS; g++) begin : g_cell
            t_entry d;
            if (g == MAX_BLOCKS - 1) begin : g_tail
                assign d = wb;
            end else begin : g_mid
                assign d = q[g+1];
            end
            bfa_cell #(.RST_VALID(g == 0)) u_cell (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_shift (shift),
                .i_entry (d),
                .o_entry (q[g])
            );
        end
    endgenerate

    assign head = q[0];

    logic [2:0]    r_state;
    logic [CW-1:0] r_cnt;
    logic [1:0]    r_op;
    logic [AW-1:0] r_req, r_addr;
    logic [AW-1:0] r_heap_base, r_heap_size;
    // allocate scan
    logic          r_bfound, r_spare, r_split, r_ins;
    logic [AW-1:0] r_bsize, r_bstart;
    // free scan
    logic          r_cfound, r_calloc, r_nfound, r_nalloc, r_pfound, r_palloc;
    logic [AW-1:0] r_csize, r_nsize, r_psize, r_pstart;
    // result
    logic          r_ovalid;
    logic [2:0]    r_ost, r_rst;
    logic [AW-1:0] r_oaddr, r_osize, r_raddr, r_rsize;

    logic          in_acc;
    logic [AW:0]   cur_end;
    logic          merge_n, merge_p;
    logic [AW-1:0] msz, psz;
    logic [AW-1:0] room, init_size;

    assign in_acc          = i_s_axis_tvalid && o_s_axis_tready;
    assign o_s_axis_tready = (r_state == S_IDLE);
    assign o_cfg_ready     = (r_state == S_IDLE);
    assign shift = (r_state == S_SCAN1) || (r_state == S_SCAN2) || (r_state == S_SCAN3);

    assign cur_end = {1'b0, r_addr} + {1'b0, r_csize};
    assign merge_n = r_nfound && !r_nalloc;
    assign merge_p = r_pfound && !r_palloc;
    assign msz     = r_csize + (merge_n ? r_nsize : '0);
    assign psz     = r_psize + msz;

    // Clamp so the heap does not run past the top of the address space.
    assign room      = ~r_heap_base;
    assign init_size = (r_heap_size != '0 && (r_heap_size - 1'b1) > room)
                       ? room + 1'b1 : r_heap_size;

    // Write-back value for the entry leaving the head.
    always_comb begin
        wb = head;
        if (r_op == ACT_INIT && r_state == S_SCAN1) begin
            wb.valid = (r_cnt == '0);
            wb.alloc = 1'b0;
            wb.start = (r_cnt == '0) ? r_heap_base : '0;
            wb.size  = (r_cnt == '0) ? init_size : '0;
        end else if (r_op == ACT_ALLOC && r_state == S_SCAN2) begin
            if (head.valid && head.start == r_bstart) begin
                wb.size  = r_req;
                wb.alloc = 1'b1;
            end else if (!head.valid && r_split && !r_ins) begin
                wb.valid = 1'b1;
                wb.alloc = 1'b0;
                wb.start = r_bstart + r_req;
                wb.size  = r_bsize - r_req;
            end
        end else if (r_op == ACT_FREE && r_state == S_SCAN3) begin
            if (head.valid && head.start == r_addr) begin
                if (merge_p) begin
                    wb = '0;
                end else begin
                    wb.size  = msz;
                    wb.alloc = 1'b0;
                end
            end else if (merge_n && head.valid && {1'b0, head.start} == cur_end) begin
                wb = '0;
            end else if (merge_p && head.valid && head.start == r_pstart) begin
                wb.size = psz;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_heap_base <= RESET_BASE;
            r_heap_size <= RESET_SIZE;
        end else if (i_cfg_valid && o_cfg_ready) begin
            case (i_cfg_index)
                REG_HEAP_BASE: r_heap_base <= i_cfg_data;
                REG_HEAP_SIZE: r_heap_size <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_cnt    <= '0;
            r_ovalid <= 1'b0;
        end else begin
            if (r_state == S_DONE && (!r_ovalid || i_m_axis_tready)) begin
                r_ovalid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_ovalid <= 1'b0;
            end
            if (shift) r_cnt <= (r_cnt == LAST) ? '0 : r_cnt + 1'b1;
            case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_op     <= i_s_axis_tuser;
                        r_req    <= i_s_axis_tdata[31:0];
                        r_addr   <= i_s_axis_tdata[63:32];
                        r_cnt    <= '0;
                        r_bfound <= 1'b0;
                        r_spare  <= 1'b0;
                        r_ins    <= 1'b0;
                        r_cfound <= 1'b0;
                        r_calloc <= 1'b0;
                        r_csize  <= '0;
                        r_nfound <= 1'b0;
                        r_nalloc <= 1'b0;
                        r_nsize  <= '0;
                        r_pfound <= 1'b0;
                        r_palloc <= 1'b0;
                        r_psize  <= '0;
                        r_pstart <= '0;
                        r_rst    <= ST_OK;
                        r_raddr  <= '0;
                        r_rsize  <= '0;
                        case (i_s_axis_tuser)
                            ACT_ALLOC: begin
                                if (i_s_axis_tdata[31:0] == '0) begin
                                    r_rst   <= ST_ZERO;
                                    r_state <= S_DONE;
                                end else begin
                                    r_state <= S_SCAN1;
                                end
                            end
                            ACT_FREE: begin
                                r_state <= (i_s_axis_tdata[63:32] == '0) ? S_DONE : S_SCAN1;
                            end
                            ACT_INIT: r_state <= S_SCAN1;
                            default:  r_state <= S_DONE;
                        endcase
                    end
                end
                S_SCAN1: begin
                    if (r_op == ACT_ALLOC) begin
                        if (!head.valid) begin
                            r_spare <= 1'b1;
                        end else if (!head.alloc && head.size >= r_req &&
                                     (!r_bfound || head.size < r_bsize ||
                                      (head.size == r_bsize && head.start < r_bstart))) begin
                            r_bfound <= 1'b1;
                            r_bsize  <= head.size;
                            r_bstart <= head.start;
                        end
                    end else if (r_op == ACT_FREE) begin
                        if (head.valid && head.start == r_addr && !r_cfound) begin
                            r_cfound <= 1'b1;
                            r_calloc <= head.alloc;
                            r_csize  <= head.size;
                        end
                    end
                    if (r_cnt == LAST) begin
                        if (r_op == ACT_INIT) begin
                            r_raddr <= r_heap_base;
                            r_rsize <= init_size;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_DEC1;
                        end
                    end
                end
                S_DEC1: begin
                    if (r_op == ACT_ALLOC) begin
                        r_split <= (r_bsize > r_req);
                        if (!r_bfound) begin
                            r_rst   <= ST_NOFIT;
                            r_state <= S_DONE;
                        end else if (r_bsize > r_req && !r_spare) begin
                            r_rst   <= ST_FULL;
                            r_state <= S_DONE;
                        end else begin
                            r_raddr <= r_bstart;
                            r_rsize <= r_req;
                            r_state <= S_SCAN2;
                        end
                    end else begin
                        if (!r_cfound || !r_calloc) begin
                            r_rst   <= ST_BADFREE;
                            r_state <= S_DONE;
                        end else begin
                            r_state <= S_SCAN2;
                        end
                    end
                end
                S_SCAN2: begin
                    if (r_op == ACT_ALLOC) begin
                        if (!head.valid && r_split) r_ins <= 1'b1;
                        if (r_cnt == LAST) r_state <= S_DONE;
                    end else begin
                        if (head.valid && {1'b0, head.start} == cur_end && r_csize != '0) begin
                            r_nfound <= 1'b1;
                            r_nalloc <= head.alloc;
                            r_nsize  <= head.size;
                        end
                        if (head.valid && head.size != '0 &&
                            ({1'b0, head.start} + {1'b0, head.size}) == {1'b0, r_addr}) begin
                            r_pfound <= 1'b1;
                            r_palloc <= head.alloc;
                            r_psize  <= head.size;
                            r_pstart <= head.start;
                        end
                        if (r_cnt == LAST) r_state <= S_DEC2;
                    end
                end
                S_DEC2: begin
                    r_raddr <= merge_p ? r_pstart : r_addr;
                    r_rsize <= merge_p ? psz : msz;
                    r_state <= S_SCAN3;
                end
                S_SCAN3: begin
                    if (r_cnt == LAST) r_state <= S_DONE;
                end
                S_DONE: begin
                    // Hold until the output register is free.
                    if (!r_ovalid || i_m_axis_tready) begin
                        r_state  <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_state == S_DONE && (!r_ovalid || i_m_axis_tready)) begin
            r_ost   <= r_rst;
            r_oaddr <= (r_rst == ST_OK) ? r_raddr : '0;
            r_osize <= (r_rst == ST_OK) ? r_rsize : '0;
        end
    end

    assign o_m_axis_tvalid = r_ovalid;
    assign o_m_axis_tuser  = r_ost;
    assign o_m_axis_tdata  = {r_osize, r_oaddr};

    `ASSERT_CLK(a_accept_leaves_idle, in_acc |=> (r_state != S_IDLE),
                "accepted item did not start work")
    `ASSERT_CLK(a_scan_wraps, (r_state == S_SCAN1 && r_cnt == LAST && r_op != ACT_INIT)
                |=> (r_state == S_DEC1), "first pass did not end on wrap")
    `ASSERT_CLK(a_err_zero_payload, (o_m_axis_tvalid && o_m_axis_tuser != ST_OK)
                |-> (o_m_axis_tdata == '0), "error result carries nonzero data")

endmodule

/* tb/tb_top.sv */
// Self-checking testbench for best_fit_block_allocator: random and directed
// alloc/free/init traffic, predicted by a scoreboard class. Depends on bfa_pkg.
`timescale 1ns / 100ps

module tb_top;
    import bfa_pkg::*;

    localparam int unsigned NBLK    = 64;
    localparam logic [1:0]  ACT_NOP = 2'd3;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED2 = 2'd2;
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED3 = 2'd3;
    localparam longint unsigned AMASK = 64'hFFFF_FFFF;

    typedef struct {
        logic [2:0]  status;
        logic [31:0] address;
        logic [31:0] block_size;
    } t_heap_result;

    class alloc_scoreboard;
        t_heap_result     expected_q[$];
        int               errors;
        longint unsigned  base_reg, size_reg;
        bit               blk_valid[NBLK], blk_alloc[NBLK];
        longint unsigned  blk_start[NBLK], blk_size[NBLK];
        logic [31:0]      live_addrs[$];

        function new();
            errors   = 0;
            base_reg = RESET_BASE;
            size_reg = RESET_SIZE;
            void'(rebuild_heap());
        endfunction

        // Returns {base, size} of the fresh heap.
        function t_heap_result rebuild_heap();
            t_heap_result r;
            longint unsigned b, s, room;
            b    = base_reg & AMASK;
            s    = size_reg;
            room = AMASK - b;
            if (s != 0 && s - 1 > room) s = room + 1;
            for (int i = 0; i < NBLK; i++) begin
                blk_valid[i] = 0; blk_alloc[i] = 0; blk_start[i] = 0; blk_size[i] = 0;
            end
            blk_valid[0] = 1; blk_start[0] = b; blk_size[0] = s;
            live_addrs.delete();
            r.status = ST_OK; r.address = b[31:0]; r.block_size = s[31:0];
            return r;
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
            if (idx == REG_HEAP_BASE) base_reg = data;
            else if (idx == REG_HEAP_SIZE) size_reg = data;
        endfunction

        function t_heap_result predict_alloc(longint unsigned req);
            t_heap_result r;
            int best, spare;
            best = -1; spare = -1;
            r.status = ST_OK; r.address = 0; r.block_size = 0;
            if (req == 0) begin
                r.status = ST_ZERO;
                return r;
            end
            for (int i = 0; i < NBLK; i++) begin
                if (!blk_valid[i]) begin
                    if (spare < 0) spare = i;
                    continue;
                end
                if (blk_alloc[i] || blk_size[i] < req) continue;
                if (best < 0 || blk_size[i] < blk_size[best] ||
                    (blk_size[i] == blk_size[best] && blk_start[i] < blk_start[best]))
                    best = i;
            end
            if (best < 0) begin
                r.status = ST_NOFIT;
                return r;
            end
            if (blk_size[best] > req) begin
                if (spare < 0) begin
                    r.status = ST_FULL;
                    return r;
                end
                blk_valid[spare] = 1;
                blk_alloc[spare] = 0;
                blk_start[spare] = (blk_start[best] + req) & AMASK;
                blk_size[spare]  = blk_size[best] - req;
                blk_size[best]   = req;
            end
            blk_alloc[best] = 1;
            r.address = blk_start[best][31:0];
            r.block_size = req[31:0];
            live_addrs.push_back(r.address);
            return r;
        endfunction

        function t_heap_result predict_free(longint unsigned addr);
            t_heap_result r;
            int cur, nxt, prv;
            longint unsigned fin;
            cur = -1; nxt = -1; prv = -1;
            r.status = ST_OK; r.address = 0; r.block_size = 0;
            if (addr == 0) return r;
            for (int i = 0; i < NBLK; i++)
                if (cur < 0 && blk_valid[i] && blk_start[i] == addr) cur = i;
            if (cur < 0 || !blk_alloc[cur]) begin
                r.status = ST_BADFREE;
                return r;
            end
            blk_alloc[cur] = 0;
            fin = blk_start[cur] + blk_size[cur];
            for (int i = 0; i < NBLK; i++) begin
                if (!blk_valid[i] || i == cur) continue;
                if (blk_start[i] == fin && blk_size[cur] != 0) nxt = i;
                if (blk_start[i] + blk_size[i] == blk_start[cur] && blk_size[i] != 0)
                    prv = i;
            end
            if (nxt >= 0 && !blk_alloc[nxt]) begin
                blk_size[cur] += blk_size[nxt];
                blk_valid[nxt] = 0; blk_size[nxt] = 0; blk_start[nxt] = 0;
            end
            if (prv >= 0 && !blk_alloc[prv]) begin
                blk_size[prv] += blk_size[cur];
                blk_valid[cur] = 0; blk_size[cur] = 0; blk_start[cur] = 0;
                cur = prv;
            end
            foreach (live_addrs[k])
                if (live_addrs[k] == addr[31:0]) begin
                    live_addrs.delete(k);
                    break;
                end
            r.address = blk_start[cur][31:0];
            r.block_size = blk_size[cur][31:0];
            return r;
        endfunction

        function void note_input(logic [1:0] action, logic [31:0] req, logic [31:0] faddr);
            t_heap_result r;
            case (action)
                ACT_ALLOC: r = predict_alloc(req);
                ACT_FREE:  r = predict_free(faddr);
                ACT_INIT:  r = rebuild_heap();
                default: begin
                    r.status = ST_OK; r.address = 0; r.block_size = 0;
                end
            endcase
            expected_q.push_back(r);
        endfunction

        function void check_result(logic [2:0] st, logic [31:0] addr, logic [31:0] sz);
            t_heap_result e;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result status=%0d address=%h size=%h",
                         $time, st, addr, sz);
                errors++;
                return;
            end
            e = expected_q.pop_front();
            if (st !== e.status) begin
                $display("%0t: status expected %0d actual %0d", $time, e.status, st);
                errors++;
            end
            if (addr !== e.address) begin
                $display("%0t: address expected %h actual %h", $time, e.address, addr);
                errors++;
            end
            if (sz !== e.block_size) begin
                $display("%0t: block_size expected %h actual %h", $time, e.block_size, sz);
                errors++;
            end
        endfunction
    endclass

    logic                 i_clk, i_rst_n;
    logic                 i_s_axis_tvalid, o_s_axis_tready;
    logic [63:0]          i_s_axis_tdata;   // request_size[31:0], free_address[63:32]
    logic [1:0]           i_s_axis_tuser;   // action[1:0]
    logic                 o_m_axis_tvalid, i_m_axis_tready;
    logic [63:0]          o_m_axis_tdata;   // address[31:0], block_size[63:32]
    logic [2:0]           o_m_axis_tuser;   // status[2:0]
    logic                 i_cfg_valid, o_cfg_ready;
    logic [CFG_IDX_W-1:0] i_cfg_index;
    logic [AW-1:0]        i_cfg_data;

    alloc_scoreboard sb;
    int burst_left;

    best_fit_block_allocator #(.MAX_BLOCKS(NBLK)) dut (.*);

    initial begin
        i_clk = 0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #50ms;
        $display("end of test: mismatches");
        $finish;
    end

    // Receiver: a new stall pattern is picked at random each time the stall counter wraps, sometimes none at all.
    int stall_mode, stall_cnt;
    always @(posedge i_clk) begin
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready)
            sb.check_result(o_m_axis_tuser, o_m_axis_tdata[31:0], o_m_axis_tdata[63:32]);
        if (stall_cnt == 0) stall_mode = $urandom_range(0, 3);
        stall_cnt = (stall_cnt + 1) % 64;
        case (stall_mode)
            0:       i_m_axis_tready <= 1'b1;
            1:       i_m_axis_tready <= ($urandom_range(0, 2) != 0);
            2:       i_m_axis_tready <= ($urandom_range(0, 7) == 0);
            default: i_m_axis_tready <= (stall_cnt < 32);
        endcase
    end

    task automatic send_item(logic [1:0] action, logic [31:0] req, logic [31:0] faddr);
        if (burst_left == 0) begin
            if (i_s_axis_tvalid) begin
                @(posedge i_clk);
                i_s_axis_tvalid <= 1'b0;
            end
            repeat ($urandom_range(0, 120)) @(posedge i_clk);
            burst_left = $urandom_range(1, 12);
            @(posedge i_clk);
        end else if (!i_s_axis_tvalid) begin
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tuser  <= action;
        i_s_axis_tdata  <= {faddr, req};
        do @(posedge i_clk); while (!o_s_axis_tready);
        sb.note_input(action, req, faddr);
        burst_left--;
        // Hold valid for the next item of the burst; drop it otherwise.
        if (burst_left == 0) i_s_axis_tvalid <= 1'b0;
    endtask

    task automatic wait_idle();
        // End the burst so the last item is not offered again.
        if (burst_left != 0) begin
            i_s_axis_tvalid <= 1'b0;
            burst_left = 0;
        end
        while (sb.expected_q.size() != 0) @(posedge i_clk);
        repeat (250) @(posedge i_clk);
    endtask

    task automatic write_cfg(logic [CFG_IDX_W-1:0] idx, logic [31:0] data);
        @(posedge i_clk);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        i_cfg_valid <= 1'b0;
    endtask

    task automatic run_random(int n, int unsigned max_req);
        logic [31:0] req, faddr;
        int r;
        for (int k = 0; k < n; k++) begin
            r = $urandom_range(0, 99);
            req = $urandom();
            faddr = $urandom();
            if (r < 50) begin
                case ($urandom_range(0, 9))
                    0:       req = 0;
                    1:       ;
                    default: req = $urandom_range(1, max_req);
                endcase
                send_item(ACT_ALLOC, req, faddr);
            end else if (r < 90) begin
                if (sb.live_addrs.size() != 0 && $urandom_range(0, 9) < 8)
                    faddr = sb.live_addrs[$urandom_range(0, sb.live_addrs.size() - 1)];
                else if ($urandom_range(0, 3) == 0)
                    faddr = 0;
                send_item(ACT_FREE, req, faddr);
            end else if (r < 95) begin
                send_item(ACT_INIT, req, faddr);
            end else begin
                send_item(ACT_NOP, req, faddr);
            end
        end
    endtask

    task automatic phase(logic [31:0] base, logic [31:0] size, int n, int unsigned max_req);
        wait_idle();
        write_cfg(REG_HEAP_BASE, base);
        write_cfg(REG_HEAP_SIZE, size);
        write_cfg($urandom_range(0, 1) ? REG_UNUSED2 : REG_UNUSED3, $urandom());
        send_item(ACT_INIT, $urandom(), $urandom());
        run_random(n, max_req);
    endtask

    initial begin
        sb = new();
        i_rst_n = 0;
        i_s_axis_tvalid = 0; i_s_axis_tdata = '0; i_s_axis_tuser = '0;
        i_m_axis_tready = 0;
        i_cfg_valid = 0; i_cfg_index = '0; i_cfg_data = '0;
        burst_left = 0; stall_mode = 0; stall_cnt = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: error cases, then split and the three merge shapes.
        send_item(ACT_ALLOC, 32'd0, 32'hFFFF_FFFF);
        send_item(ACT_ALLOC, 32'hFFFF_FFFF, 32'd0);
        send_item(ACT_FREE, 32'hFFFF_FFFF, 32'd0);
        send_item(ACT_FREE, 32'd0, 32'h0001_2345);
        send_item(ACT_NOP, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        send_item(ACT_ALLOC, 32'd100, 32'd0);
        send_item(ACT_ALLOC, 32'd200, 32'd0);
        send_item(ACT_ALLOC, 32'd100, 32'd0);
        send_item(ACT_FREE, 32'd0, RESET_BASE + 32'd100);  // neighbors both busy
        send_item(ACT_FREE, 32'd0, RESET_BASE);            // merge with next
        send_item(ACT_FREE, 32'd0, RESET_BASE + 32'd300);  // merge both sides
        send_item(ACT_FREE, 32'd0, RESET_BASE + 32'd300);  // already free
        send_item(ACT_INIT, 32'd0, 32'd0);
        send_item(ACT_ALLOC, RESET_SIZE, 32'd0);           // exact fit, no split
        send_item(ACT_FREE, 32'd0, RESET_BASE);
        send_item(ACT_ALLOC, RESET_SIZE + 32'd1, 32'd0);
        run_random(100, 40000);

        phase(32'h0000_0000, 32'd4096, 120, 600);          // block at address zero
        phase(32'hFFFF_F000, 32'hFFFF_FFFF, 120, 700);     // size clamped at top
        phase(32'h0000_0100, 32'd0, 15, 4);                // empty heap
        phase(32'hFFFF_FFFF, 32'd1, 20, 2);
        phase(32'h8000_0000, 32'd200, 150, 3);             // fills the table
        phase(32'h0000_0000, 32'hFFFF_FFFF, 120, 32'h7FFF_FFFF);
        phase(32'h5A5A_0000, 32'd100000, 120, 9000);

        wait_idle();
        if (sb.errors == 0 && sb.expected_q.size() == 0)
            $display("end of test: clean");
        else
            $display("end of test: mismatches");
        $finish;
    end
endmodule
